// File: rtl/core/bbtv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbtv_pkg
// Shared opcodes, widths and types for the bunch time vote block.
// ----------------------------------------------------------------------------
package bbtv_pkg;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_VOTE   = 2'd1;
	localparam logic [1:0] OP_PHOTON = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	localparam logic [1:0] DEC_UNIQUE = 2'd0;
	localparam logic [1:0] DEC_PHOTON = 2'd1;
	localparam logic [1:0] DEC_SUMS   = 2'd2;

	localparam int unsigned PERIOD_RESET = 2004;
	localparam int unsigned QW = 34;

	// Request to the shared divider and its answer.
	typedef struct packed {
		logic        go;
		logic [32:0] mag;
		logic [15:0] period;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [QW-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/bbtv_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbtv_div
// Restoring divider, one quotient bit per cycle: (2*mag + p) / (2*p).
// ----------------------------------------------------------------------------
module bbtv_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bbtv_pkg::div_req_t req,
	output bbtv_pkg::div_rsp_t    rsp
);
	localparam int W = bbtv_pkg::QW;

	logic [W-1:0] num_q;
	logic [W-1:0] quo_q;
	logic [17:0]  rem_q;
	logic [16:0]  den_q;
	logic [5:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [17:0]  trial;

	assign trial = {rem_q[16:0], num_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= 6'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= {req.mag, 1'b0} + {18'd0, req.period};
			den_q <= {req.period, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule
`default_nettype wire

// File: rtl/core/beam_bunch_time_vote.sv
`default_nettype none
// ----------------------------------------------------------------------------
// beam_bunch_time_vote
// Bunch selection by vote of particle and photon times around a reference.
// ----------------------------------------------------------------------------
// Commands enter on start while busy is low. Start-event clears all buckets,
// one bucket a cycle; the same clearing pass runs after reset, so busy stays
// high until it ends. A particle vote before the first photon, or a later
// photon, keeps busy high while the shared restoring divider rounds by the
// bunch period and raises its done flag; then, if the shift is in range, the
// bucket is read and written back in the bucket memory. The first photon of
// an event runs a pass over all buckets to mark the eligible ones while the
// divider works. Finish takes up to three scans over the buckets, one bucket
// a cycle through the single memory read port, then forms the bunch time
// product; with no votes it skips the scans.
// Its word shows for one cycle on result_valid, in the first cycle with busy
// low; the receiver cannot stall, so it must take the word in that cycle.
// Configuration writes are accepted whenever cfg_ready is high, which is
// always, and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module beam_bunch_time_vote #(
	parameter int BUCKETS   = 128,
	parameter int MAX_VOTES = 255
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [31:0] time_ps,
	input  wire logic [7:0]         track_ndf,
	input  wire logic [23:0]        track_chisq,
	input  wire logic [19:0]        shower_energy_mev,
	input  wire logic               tie_by_energy,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data,
	output logic                    result_valid,
	output logic signed [6:0]       best_shift,
	output logic [7:0]              vote_count,
	output logic signed [31:0]      bunch_time_ps,
	output logic                    has_votes,
	output logic [1:0]              decided_by,
	output logic                    range_overflow
);
	localparam int BW   = $clog2(BUCKETS);
	localparam int HALF = BUCKETS / 2;
	localparam int VW   = $clog2(2 * MAX_VOTES + 1);
	localparam int MW   = $clog2(MAX_VOTES + 1);
	localparam logic [VW-1:0] MAXV  = VW'(MAX_VOTES);
	localparam logic [VW-1:0] MAXV2 = VW'(2 * MAX_VOTES);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_UPD   = 4'd4;
	localparam logic [3:0] S_ELIG  = 4'd5;
	localparam logic [3:0] S_SCAN1 = 4'd6;
	localparam logic [3:0] S_SCAN2 = 4'd7;
	localparam logic [3:0] S_SCAN3 = 4'd8;
	localparam logic [3:0] S_MUL   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	typedef struct packed {
		logic [VW-1:0] votes;
		logic [15:0]   ndf;
		logic [31:0]   chi;
		logic [27:0]   en;
		logic          elig;
	} bkt_t;

	bkt_t mem [BUCKETS];
	bkt_t rd_q;

	logic [3:0]  st_q;
	logic [15:0] period_q;
	logic signed [31:0] ref_q;
	logic [MW-1:0] pmax_q;
	logic          ph_q, ovf_q;
	logic [1:0]    op_q;
	logic          neg_q, en_mode_q;
	logic [7:0]    ndf_in_q;
	logic [23:0]   chi_in_q;
	logic [19:0]   en_in_q;
	logic [BW-1:0] idx_q;
	logic [BW:0]   scan_q;
	logic          rd_act_q;
	logic [BW-1:0] rd_idx_q;
	logic [BW-1:0] best_q;
	logic [BW:0]   cnt_q;
	logic [VW-1:0] top_q;
	logic          have_q;
	bkt_t          bref_q;
	logic [1:0]    dec_q;
	logic signed [49:0] prod_q;
	logic          qrdy_q;

	logic          wr_en;
	logic [BW-1:0] wr_addr;
	bkt_t          wr_data;
	logic [BW-1:0] rd_addr;

	bbtv_pkg::div_req_t dreq;
	bbtv_pkg::div_rsp_t drsp;

	logic signed [32:0] diff;
	logic [15:0] per_eff;
	logic        q_big;
	logic [BW-1:0] qidx;
	logic        q_ok;

	bbtv_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cfg_ready = 1'b1;
	assign busy      = (st_q != S_IDLE);
	assign per_eff   = (period_q == 16'd0) ? 16'd1 : period_q;
	assign diff      = 33'(time_ps) - 33'(ref_q);

	always_comb begin
		dreq.go     = start && !busy && (opcode == bbtv_pkg::OP_VOTE ||
			opcode == bbtv_pkg::OP_PHOTON) && !(opcode == bbtv_pkg::OP_VOTE && ph_q);
		dreq.mag    = diff[32] ? 33'(-diff) : 33'(diff);
		dreq.period = per_eff;
	end

	// Shift range check and bucket index from the quotient.
	always_comb begin
		q_big = (drsp.quot > bbtv_pkg::QW'(HALF));
		q_ok  = !q_big && !(!neg_q && drsp.quot == bbtv_pkg::QW'(HALF));
		if (neg_q)
			qidx = BW'(HALF) - BW'(drsp.quot);
		else
			qidx = BW'(HALF) + BW'(drsp.quot);
	end

	// Memory write port and read address logic.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		rd_addr = idx_q;
		case (st_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			S_UPD: begin
				wr_en = 1'b1;
				if (op_q == bbtv_pkg::OP_VOTE) begin
					if (rd_q.votes < MAXV)
						wr_data.votes = rd_q.votes + VW'(1);
					wr_data.ndf = (17'(rd_q.ndf) + 17'(ndf_in_q) > 17'hFFFF) ?
						16'hFFFF : rd_q.ndf + 16'(ndf_in_q);
					wr_data.chi = (33'(rd_q.chi) + 33'(chi_in_q) > 33'hFFFFFFFF) ?
						32'hFFFFFFFF : rd_q.chi + 32'(chi_in_q);
					wr_data.en = (29'(rd_q.en) + 29'(en_in_q) > 29'h0FFFFFFF) ?
						28'hFFFFFFF : rd_q.en + 28'(en_in_q);
				end else if (rd_q.elig && rd_q.votes < MAXV2) begin
					wr_data.votes = rd_q.votes + VW'(1);
				end
			end
			S_ELIG: begin
				rd_addr = scan_q[BW-1:0];
				wr_addr = rd_idx_q;
				wr_en   = rd_act_q;
				wr_data.elig = (pmax_q != '0) && (rd_q.votes == VW'(pmax_q));
			end
			S_SCAN1, S_SCAN2, S_SCAN3: rd_addr = scan_q[BW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Candidate test for the bucket whose data sits in rd_q.
	logic cand1, cand2, better;
	always_comb begin
		cand1 = ph_q ? rd_q.elig : (rd_q.votes == VW'(pmax_q));
		cand2 = cand1 && (!ph_q || rd_q.votes == top_q);
		if (en_mode_q)
			better = rd_q.en > bref_q.en;
		else
			better = (rd_q.ndf > bref_q.ndf) ||
				(rd_q.ndf == bref_q.ndf && rd_q.chi < bref_q.chi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_CLR;
			period_q     <= 16'(bbtv_pkg::PERIOD_RESET);
			ref_q        <= '0;
			pmax_q       <= '0;
			ph_q         <= 1'b0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			scan_q       <= '0;
			rd_act_q     <= 1'b0;
			result_valid <= 1'b0;
			qrdy_q       <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready)
				period_q <= cfg_data;
			// The first photon of an event finishes its division during the
			// eligibility pass, so the done pulse is kept until the next launch.
			if (dreq.go)
				qrdy_q <= 1'b0;
			else if (drsp.done)
				qrdy_q <= 1'b1;
			case (st_q)
				S_IDLE: if (start) begin
					op_q      <= opcode;
					neg_q     <= diff[32];
					ndf_in_q  <= track_ndf;
					chi_in_q  <= track_chisq;
					en_in_q   <= shower_energy_mev;
					en_mode_q <= tie_by_energy;
					case (opcode)
						bbtv_pkg::OP_START: begin
							ref_q  <= time_ps;
							pmax_q <= '0;
							ph_q   <= 1'b0;
							ovf_q  <= 1'b0;
							idx_q  <= '0;
							st_q   <= S_CLR;
						end
						bbtv_pkg::OP_VOTE: if (!ph_q) st_q <= S_DIV;
						bbtv_pkg::OP_PHOTON: begin
							if (!ph_q) begin
								ph_q     <= 1'b1;
								scan_q   <= '0;
								rd_act_q <= 1'b0;
								st_q     <= S_ELIG;
							end else begin
								st_q <= S_DIV;
							end
						end
						default: begin
							scan_q   <= '0;
							rd_act_q <= 1'b0;
							cnt_q    <= '0;
							top_q    <= '0;
							best_q   <= BW'(HALF);
							dec_q    <= bbtv_pkg::DEC_UNIQUE;
							st_q     <= (pmax_q == '0) ? S_MUL : S_SCAN1;
						end
					endcase
				end
				S_CLR: begin
					idx_q <= idx_q + BW'(1);
					if (idx_q == BW'(BUCKETS - 1))
						st_q <= S_IDLE;
				end
				S_ELIG: begin
					rd_act_q <= !scan_q[BW];
					rd_idx_q <= scan_q[BW-1:0];
					scan_q   <= scan_q + (BW+1)'(1);
					if (rd_act_q && rd_idx_q == BW'(BUCKETS - 1))
						st_q <= S_DIV;
				end
				S_DIV: if (drsp.done || qrdy_q) begin
					if (q_ok) begin
						idx_q <= qidx;
						st_q  <= S_RD;
					end else begin
						if (op_q == bbtv_pkg::OP_VOTE)
							ovf_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				S_RD: st_q <= S_UPD;
				S_UPD: begin
					if (op_q == bbtv_pkg::OP_VOTE && wr_data.votes > VW'(pmax_q))
						pmax_q <= MW'(wr_data.votes);
					st_q <= S_IDLE;
				end
				S_SCAN1, S_SCAN2, S_SCAN3: begin
					rd_act_q <= !scan_q[BW];
					rd_idx_q <= scan_q[BW-1:0];
					scan_q   <= scan_q + (BW+1)'(1);
					if (rd_act_q) begin
						if (st_q == S_SCAN1) begin
							if (cand1) begin
								if (cnt_q == '0) best_q <= rd_idx_q;
								cnt_q <= cnt_q + (BW+1)'(1);
								if (rd_q.votes > top_q) top_q <= rd_q.votes;
							end
						end else if (st_q == S_SCAN2) begin
							if (cand2) begin
								if (cnt_q == '0) best_q <= rd_idx_q;
								cnt_q <= cnt_q + (BW+1)'(1);
							end
						end else if (cand2 && (!have_q || better)) begin
							best_q <= rd_idx_q;
							bref_q <= rd_q;
							have_q <= 1'b1;
						end
					end
					if (rd_act_q && rd_idx_q == BW'(BUCKETS - 1)) begin
						scan_q   <= '0;
						rd_act_q <= 1'b0;
						have_q   <= 1'b0;
						if (st_q == S_SCAN1) begin
							if (cnt_q + (cand1 ? 1 : 0) > 1 && ph_q) begin
								cnt_q <= '0;
								st_q  <= S_SCAN2;
							end else if (cnt_q + (cand1 ? 1 : 0) > 1) begin
								dec_q <= bbtv_pkg::DEC_SUMS;
								st_q  <= S_SCAN3;
							end else begin
								st_q <= S_MUL;
							end
						end else if (st_q == S_SCAN2) begin
							if (cnt_q + (cand2 ? 1 : 0) > 1) begin
								dec_q <= bbtv_pkg::DEC_SUMS;
								st_q  <= S_SCAN3;
							end else begin
								dec_q <= bbtv_pkg::DEC_PHOTON;
								st_q  <= S_MUL;
							end
						end else begin
							st_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q <= $signed({1'b0, per_eff}) *
						$signed(34'(signed'(BW'(best_q) - BW'(HALF))));
					st_q <= S_OUT;
				end
				S_OUT: begin
					result_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic signed [50:0] bt_sum;
	always_comb bt_sum = 51'(prod_q) + 51'(ref_q);

	always_ff @(posedge clk) begin
		if (st_q == S_OUT) begin
			best_shift     <= 7'(signed'(BW'(best_q) - BW'(HALF)));
			vote_count     <= (pmax_q > MW'(255)) ? 8'd255 : 8'(pmax_q);
			has_votes      <= (pmax_q != '0);
			decided_by     <= dec_q;
			range_overflow <= ovf_q;
			if (bt_sum > 51'sd2147483647)
				bunch_time_ps <= 32'sh7FFFFFFF;
			else if (bt_sum < -51'sd2147483648)
				bunch_time_ps <= 32'sh80000000;
			else
				bunch_time_ps <= 32'(bt_sum);
		end
	end

`ifndef SYNTH
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> st_q == S_IDLE)
		else $error("result shown while busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.go |=> busy)
		else $error("divider launched without busy");
	a_dec_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (decided_by != 2'd3))
		else $error("bad decided_by");
`endif
endmodule
`default_nettype wire

// File: bench/beam_bunch_time_vote_tb.sv
// ----------------------------------------------------------------------------
// beam_bunch_time_vote_tb
// Self-checking bench for the bunch time vote block. Events of random shape
// are issued through the command port. A behavioral scoreboard predicts every
// finish word, and each word on the result strobe is compared field by field.
// ----------------------------------------------------------------------------
module beam_bunch_time_vote_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = 128;
	localparam int HB = NB / 2;
	localparam int VMAX = 255;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic signed [6:0]  shift;
		logic [7:0]         votes;
		logic signed [31:0] btime;
		logic               has;
		logic [1:0]         dec;
		logic               ovf;
	} bunch_word_t;

	// Scoreboard: a behavioral copy of the vote state and the queue of
	// finish words that are still due from the block.
	class bunch_vote_board;
		bit [15:0] period;
		longint ref_t;
		int unsigned votes[NB];
		int unsigned ndf_sum[NB];
		longint unsigned chi_sum[NB];
		int unsigned en_sum[NB];
		bit elig[NB];
		int unsigned top_votes;
		bit photon_seen, overflow;
		bunch_word_t due[$];
		int errors, words, checked;

		function new();
			period = 16'(bbtv_pkg::PERIOD_RESET);
			ref_t = 0;
			clear();
			errors = 0;
			words = 0;
			checked = 0;
		endfunction

		function void clear();
			for (int i = 0; i < NB; i++) begin
				votes[i] = 0;
				ndf_sum[i] = 0;
				chi_sum[i] = 0;
				en_sum[i] = 0;
				elig[i] = 0;
			end
			top_votes = 0;
			photon_seen = 0;
			overflow = 0;
		endfunction

		// Rounds half away from zero; returns -1 for a shift out of range.
		function int bucket_for(longint t);
			longint d;
			longint unsigned mag, p, q;
			d = t - ref_t;
			mag = d < 0 ? -d : d;
			p = period == 0 ? 1 : period;
			q = (2 * mag + p) / (2 * p);
			if (q > HB) return -1;
			if (d >= 0 && q >= HB) return -1;
			return d < 0 ? HB - int'(q) : HB + int'(q);
		endfunction

		function void note_command(logic [1:0] op, logic signed [31:0] t,
				logic [7:0] ndf, logic [23:0] chi, logic [19:0] en, logic tbe);
			int b, cnt, best, dec;
			int unsigned top;
			bit cand[NB];
			bit have;
			longint bt;
			bunch_word_t w;
			case (op)
				bbtv_pkg::OP_START: begin
					clear();
					ref_t = t;
				end
				bbtv_pkg::OP_VOTE: begin
					if (!photon_seen) begin
						b = bucket_for(t);
						if (b < 0) overflow = 1;
						else begin
							if (votes[b] < VMAX) votes[b]++;
							ndf_sum[b] = (ndf_sum[b] + ndf > 65535) ? 65535
								: ndf_sum[b] + ndf;
							chi_sum[b] = (chi_sum[b] + chi > 64'hFFFFFFFF) ? 64'hFFFFFFFF
								: chi_sum[b] + chi;
							en_sum[b] = (en_sum[b] + en > 32'h0FFFFFFF) ? 32'h0FFFFFFF
								: en_sum[b] + en;
							if (votes[b] > top_votes) top_votes = votes[b];
						end
					end
				end
				bbtv_pkg::OP_PHOTON: begin
					if (!photon_seen) begin
						photon_seen = 1;
						for (int i = 0; i < NB; i++)
							elig[i] = top_votes > 0 && votes[i] == top_votes;
					end
					b = bucket_for(t);
					if (b >= 0 && elig[b] && votes[b] < 2 * VMAX) votes[b]++;
				end
				default: begin
					cnt = 0;
					best = HB;
					dec = 0;
					if (top_votes > 0) begin
						for (int i = 0; i < NB; i++) begin
							cand[i] = photon_seen ? elig[i] : votes[i] == top_votes;
							if (cand[i]) begin
								if (cnt == 0) best = i;
								cnt++;
							end
						end
						if (cnt > 1 && photon_seen) begin
							top = 0;
							for (int i = 0; i < NB; i++)
								if (cand[i] && votes[i] > top) top = votes[i];
							cnt = 0;
							for (int i = 0; i < NB; i++) begin
								cand[i] = cand[i] && votes[i] == top;
								if (cand[i]) begin
									if (cnt == 0) best = i;
									cnt++;
								end
							end
							if (cnt == 1) dec = bbtv_pkg::DEC_PHOTON;
						end
						if (cnt > 1) begin
							have = 0;
							dec = bbtv_pkg::DEC_SUMS;
							for (int i = 0; i < NB; i++) begin
								if (cand[i]) begin
									if (tbe) begin
										if (!have || en_sum[i] > en_sum[best]) best = i;
									end else if (!have || ndf_sum[i] > ndf_sum[best] ||
											(ndf_sum[i] == ndf_sum[best] &&
											chi_sum[i] < chi_sum[best])) begin
										best = i;
									end
									have = 1;
								end
							end
						end
					end
					bt = ref_t + longint'(period == 0 ? 1 : period) * (best - HB);
					if (bt > 64'sd2147483647) bt = 64'sd2147483647;
					if (bt < -64'sd2147483648) bt = -64'sd2147483648;
					w.shift = 7'(best - HB);
					w.votes = top_votes > 255 ? 8'd255 : 8'(top_votes);
					w.btime = 32'(bt);
					w.has = top_votes > 0;
					w.dec = 2'(dec);
					w.ovf = overflow;
					due = {due, w};
					words++;
				end
			endcase
		endfunction

		function void check_word(bunch_word_t got);
			bunch_word_t w;
			if (due.size() == 0) begin
				$display("%0t: result word with none due", $realtime);
				errors++;
				return;
			end
			w = due.pop_front();
			checked++;
			if (got.shift !== w.shift) begin
				$display("%0t: best_shift exp %0d got %0d", $realtime, w.shift, got.shift);
				errors++;
			end
			if (got.votes !== w.votes) begin
				$display("%0t: vote_count exp %0d got %0d", $realtime, w.votes, got.votes);
				errors++;
			end
			if (got.btime !== w.btime) begin
				$display("%0t: bunch_time_ps exp %0d got %0d", $realtime, w.btime,
					got.btime);
				errors++;
			end
			if (got.has !== w.has) begin
				$display("%0t: has_votes exp %0b got %0b", $realtime, w.has, got.has);
				errors++;
			end
			if (got.dec !== w.dec) begin
				$display("%0t: decided_by exp %0d got %0d", $realtime, w.dec, got.dec);
				errors++;
			end
			if (got.ovf !== w.ovf) begin
				$display("%0t: range_overflow exp %0b got %0b", $realtime, w.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] opcode = bbtv_pkg::OP_START;
	logic signed [31:0] time_ps = 0;
	logic [7:0] track_ndf = 0;
	logic [23:0] track_chisq = 0;
	logic [19:0] shower_energy_mev = 0;
	logic tie_by_energy = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = 0;
	logic result_valid;
	logic signed [6:0] best_shift;
	logic [7:0] vote_count;
	logic signed [31:0] bunch_time_ps;
	logic has_votes;
	logic [1:0] decided_by;
	logic range_overflow;

	bunch_vote_board board = new();
	int idle_cycles = 0;
	int events = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	beam_bunch_time_vote u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.time_ps(time_ps), .track_ndf(track_ndf), .track_chisq(track_chisq),
		.shower_energy_mev(shower_energy_mev), .tie_by_energy(tie_by_energy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .best_shift(best_shift), .vote_count(vote_count),
		.bunch_time_ps(bunch_time_ps), .has_votes(has_votes), .decided_by(decided_by),
		.range_overflow(range_overflow)
	);

	// The result strobe lasts one cycle and cannot be stalled, so every edge
	// with it high carries a word that must be checked.
	always @(posedge clk) begin
		bunch_word_t got;
		if (arst_n && result_valid) begin
			got.shift = best_shift;
			got.votes = vote_count;
			got.btime = bunch_time_ps;
			got.has = has_votes;
			got.dec = decided_by;
			got.ovf = range_overflow;
			board.check_word(got);
		end
	end

	// Watchdog: counts edges with no command, no word and no config write.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("beam_bunch_time_vote_tb: errors");
			$finish;
		end
	end

	// Issues one command word after a random gap and waits for its acceptance.
	// Start stays high after acceptance; a gap or a drain lowers it, so a word
	// with no gap follows the previous one directly.
	task automatic send_word(logic [1:0] op, logic signed [31:0] t, logic [7:0] ndf,
			logic [23:0] chi, logic [19:0] en, logic tbe);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		opcode <= op;
		time_ps <= t;
		track_ndf <= ndf;
		track_chisq <= chi;
		shower_energy_mev <= en;
		tie_by_energy <= tbe;
		do @(posedge clk); while (busy);
		board.note_command(op, t, ndf, chi, en, tbe);
		if (op == bbtv_pkg::OP_START) events++;
	endtask

	// Waits until every word has come, then lets a finish scan drain.
	task automatic drain();
		start <= 0;
		while (board.due.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (3 * NB + 20) @(posedge clk);
	endtask

	task automatic write_period(logic [15:0] p);
		cfg_valid <= 1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.period = p;
	endtask

	// A particle time near a given shift, with a residue that sometimes lands
	// exactly on the rounding midpoint.
	function automatic logic signed [31:0] time_near(int sh, logic [15:0] p);
		longint pp, t;
		pp = p == 0 ? 1 : p;
		case ($urandom_range(0, 3))
			0: t = board.ref_t + sh * pp + pp / 2;
			1: t = board.ref_t + sh * pp - pp / 2;
			default: t = board.ref_t + sh * pp + $signed($urandom_range(0, 2 * pp)) - pp;
		endcase
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		return 32'(t);
	endfunction

	// One event: a reference, particle votes over a few shifts, maybe photons,
	// then one or two finishes. Small shift spreads make ties common.
	task automatic run_event(int n_votes);
		logic signed [31:0] r;
		int spread, base, nph;
		r = ($urandom_range(0, 9) == 0) ? $signed($urandom())
			: $signed($urandom_range(0, 4000000)) - 2000000;
		send_word(bbtv_pkg::OP_START, r, 8'($urandom()), 24'($urandom()),
			20'($urandom()), 1'($urandom()));
		spread = $urandom_range(1, 4);
		base = $signed($urandom_range(0, 20)) - 10;
		for (int i = 0; i < n_votes; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(bbtv_pkg::OP_VOTE, $urandom(), 8'($urandom()), 24'($urandom()),
					20'($urandom()), 0);
			else
				send_word(bbtv_pkg::OP_VOTE,
					time_near(base + $urandom_range(0, spread - 1), board.period),
					$urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(0, 40)),
					$urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 5000)),
					$urandom_range(0, 3) == 0 ? 20'hFFFFF : 20'($urandom_range(0, 9)), 0);
		end
		if ($urandom_range(0, 1)) begin
			nph = $urandom_range(1, 5);
			for (int i = 0; i < nph; i++)
				send_word(bbtv_pkg::OP_PHOTON, time_near(base + $urandom_range(0, spread - 1),
					board.period), 0, 0, 0, 0);
			if ($urandom_range(0, 3) == 0)
				send_word(bbtv_pkg::OP_VOTE, time_near(base, board.period), 1, 1, 1, 0);
		end
		send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 1'($urandom()));
		if ($urandom_range(0, 7) == 0)
			send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 1'($urandom()));
	endtask

	initial begin
		int sent;
		logic [15:0] periods[6] = '{16'd2004, 16'd1, 16'd0, 16'd65535, 16'd7, 16'd300};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: finish with no votes, both range edges, overflow, midpoint
		// rounding, photons with no votes, full saturation of one bucket.
		send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_START, 32'sh7FFFFFFF, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_VOTE, 32'sh80000000, 8'hFF, 24'hFFFFFF, 20'hFFFFF, 0);
		send_word(bbtv_pkg::OP_PHOTON, 32'sh7FFFFFFF, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 1);
		send_word(bbtv_pkg::OP_START, 0, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_VOTE, -32'sd64 * 2004, 1, 2, 3, 0);
		send_word(bbtv_pkg::OP_VOTE, 32'sd63 * 2004, 1, 2, 3, 0);
		send_word(bbtv_pkg::OP_VOTE, 32'sd64 * 2004 - 1002, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_VOTE, 32'sd1002, 5, 0, 0, 0);
		send_word(bbtv_pkg::OP_VOTE, -32'sd1002, 5, 0, 0, 0);
		send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 1);
		drain();
		write_period(16'd1);
		send_word(bbtv_pkg::OP_START, -32'sh80000000, 0, 0, 0, 0);
		for (int i = 0; i < 260; i++)
			send_word(bbtv_pkg::OP_VOTE, -32'sh80000000, 8'hFF, 24'hFFFFFF, 20'hFFFFF, 0);
		send_word(bbtv_pkg::OP_VOTE, -32'sh80000000 + 5, 1, 1, 1, 0);
		for (int i = 0; i < 3; i++)
			send_word(bbtv_pkg::OP_PHOTON, -32'sh80000000, 0, 0, 0, 0);
		send_word(bbtv_pkg::OP_FINISH, 0, 0, 0, 0, 0);
		drain();

		// Each random event carries about nine command words on average.
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_period(periods[ph]);
			while (sent < (ph + 1) * 1400 / 6) begin
				run_event($urandom_range(0, 3) == 0 ? $urandom_range(0, 1)
					: $urandom_range(2, 12));
				sent = sent + 9;
			end
			drain();
		end

		$display("covered %0d events over 6 bunch periods; %0d finish words checked",
			events, board.checked);
		if (board.errors == 0 && board.due.size() == 0)
			$display("beam_bunch_time_vote_tb: clean");
		else
			$display("beam_bunch_time_vote_tb: errors");
		$finish;
	end
endmodule
